/* rtl/core/bdb_pkg.sv */
// package for the button debouncer: payload structs, register indexes, reset values
// no dependencies; every module of the block imports it
`timescale 1ns / 1ps

package bdb_pkg;

  localparam int unsigned CountW = 8;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SHORT_COUNT   = 2'd0,
    REG_LONG_COUNT    = 2'd1,
    REG_RELEASE_COUNT = 2'd2
  } bdb_reg_e;

  localparam logic [CountW-1:0] ShortCountRst   = 8'd4;
  localparam logic [CountW-1:0] LongCountRst    = 8'd70;
  localparam logic [CountW-1:0] ReleaseCountRst = 8'd4;
  localparam logic [CountW-1:0] RunMax          = 8'd255;

  typedef struct packed {
    logic pin_level;
    logic take_short;
    logic take_long;
  } bdb_in_t;

  typedef struct packed {
    logic short_press;
    logic long_press;
    logic stable_level;
  } bdb_out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [CountW-1:0]  data;
  } bdb_cfg_wr_t;

  typedef struct packed {
    logic [CountW-1:0] short_count;
    logic [CountW-1:0] long_count;
    logic [CountW-1:0] release_count;
  } bdb_cfg_t;

endpackage

/* rtl/core/bdb_stream_if.sv */
// valid/ready channel carrying one payload struct per item
// payload type comes from bdb_pkg at the point of instantiation
`timescale 1ns / 1ps

interface bdb_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/button_short_long_press_debouncer.sv */
// top level of the push-button debouncer with short and long press events
// depends on bdb_pkg, bdb_stream_if, bdb_cfg_regs, bdb_step, bdb_out_reg
//
//   channel  dir  payload                                  handshake
//   cfg_i    in   index[1:0], data[7:0]                    valid/ready, ready always high
//   in_i     in   pin_level, take_short, take_long         valid/ready
//   out_o    out  short_press, long_press, stable_level    valid/ready
//
// one item per cycle while out_o keeps up; its result is registered and shows in the cycle after acceptance
// in_i.ready is high while the result register is empty or being drained
// a stall on out_o holds one result and stops intake until it is taken
// reset puts counts to 4 / 70 / 4, both levels to released, flags and trigger clear
`timescale 1ns / 1ps

module button_short_long_press_debouncer import bdb_pkg::*; (
  input logic          clk_i,
  input logic          rst_ni,
  bdb_stream_if.sink   cfg_i,
  bdb_stream_if.sink   in_i,
  bdb_stream_if.source out_o
);

  bdb_cfg_t cfg;
  bdb_out_t res;
  logic     space, acc;

  assign in_i.ready = space;
  assign acc        = in_i.valid && space;

  bdb_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .wr_valid_i (cfg_i.valid),
    .wr_ready_o (cfg_i.ready),
    .wr_i       (cfg_i.payload),
    .cfg_o      (cfg)
  );

  bdb_step u_step (
    .clk_i,
    .rst_ni,
    .cfg_i  (cfg),
    .acc_i  (acc),
    .item_i (in_i.payload),
    .res_o  (res)
  );

  bdb_out_reg u_out (
    .clk_i,
    .rst_ni,
    .load_i  (acc),
    .res_i   (res),
    .space_o (space),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (out_o.payload)
  );

endmodule

/* rtl/core/bdb_cfg_regs.sv */
// configuration registers: short_count, long_count, release_count
// depends on bdb_pkg
`timescale 1ns / 1ps

module bdb_cfg_regs import bdb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_valid_i,
  output logic        wr_ready_o,
  input  bdb_cfg_wr_t wr_i,
  output bdb_cfg_t    cfg_o
);

  bdb_cfg_t cfg_q, cfg_d;

  assign wr_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_valid_i) begin
      unique case (wr_i.index)
        REG_SHORT_COUNT:   cfg_d.short_count   = wr_i.data;
        REG_LONG_COUNT:    cfg_d.long_count    = wr_i.data;
        REG_RELEASE_COUNT: cfg_d.release_count = wr_i.data;
        default:           cfg_d = cfg_q;  // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_count   <= ShortCountRst;
      cfg_q.long_count    <= LongCountRst;
      cfg_q.release_count <= ReleaseCountRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/bdb_step.sv */
// debounce state and per-tick update: short path, long path, event flags
// depends on bdb_pkg
`timescale 1ns / 1ps

module bdb_step import bdb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  bdb_cfg_t cfg_i,
  input  logic     acc_i,
  input  bdb_in_t  item_i,
  output bdb_out_t res_o
);

  logic [CountW-1:0] short_run_q, short_run_d;
  logic [CountW-1:0] long_run_q, long_run_d;
  logic              short_level_q, short_level_d;
  logic              long_level_q, long_level_d;
  logic              press_armed_q, press_armed_d;
  logic              short_flag_q, short_flag_d;
  logic              long_flag_q, long_flag_d;

  logic [CountW-1:0] short_inc, long_inc, long_thr;
  logic              short_fire, long_fire, sf, lf, pin;

  always_comb begin
    pin       = item_i.pin_level;
    short_inc = (short_run_q == RunMax) ? short_run_q : short_run_q + 8'd1;
    long_inc  = (long_run_q == RunMax) ? long_run_q : long_run_q + 8'd1;
    long_thr  = pin ? cfg_i.release_count : cfg_i.long_count;

    short_fire = (pin != short_level_q) && (short_inc >= cfg_i.short_count);
    long_fire  = (pin != long_level_q) && (long_inc >= long_thr);

    short_run_d   = (pin == short_level_q || short_fire) ? '0 : short_inc;
    long_run_d    = (pin == long_level_q || long_fire) ? '0 : long_inc;
    short_level_d = short_fire ? pin : short_level_q;
    long_level_d  = long_fire ? pin : long_level_q;

    // short path arms first, long-press entry then disarms in the same tick
    press_armed_d = press_armed_q;
    if (short_fire && !pin) press_armed_d = 1'b1;
    if (long_fire && !pin)  press_armed_d = 1'b0;

    sf = short_flag_q | (short_fire & pin & press_armed_q);
    lf = long_flag_q | (long_fire & ~pin);

    res_o.short_press  = sf;
    res_o.long_press   = lf;
    res_o.stable_level = short_level_d;

    short_flag_d = sf & ~item_i.take_short;
    long_flag_d  = lf & ~item_i.take_long;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_run_q   <= '0;
      long_run_q    <= '0;
      short_level_q <= 1'b1;
      long_level_q  <= 1'b1;
      press_armed_q <= 1'b0;
      short_flag_q  <= 1'b0;
      long_flag_q   <= 1'b0;
    end else if (acc_i) begin
      short_run_q   <= short_run_d;
      long_run_q    <= long_run_d;
      short_level_q <= short_level_d;
      long_level_q  <= long_level_d;
      press_armed_q <= press_armed_d;
      short_flag_q  <= short_flag_d;
      long_flag_q   <= long_flag_d;
    end
  end

  a_take_short_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && item_i.take_short |=> !short_flag_q)
    else $error("short flag survived a take");

  a_take_long_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && item_i.take_long |=> !long_flag_q)
    else $error("long flag survived a take");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc_i |=> $stable(short_level_q) && $stable(long_level_q) && $stable(short_run_q)
               && $stable(long_run_q) && $stable(press_armed_q))
    else $error("debounce state moved without an item");

  a_long_entry_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(long_level_q) |-> !press_armed_q && long_flag_q == !$past(item_i.take_long))
    else $error("long press entry did not disarm or flag");

endmodule

/* rtl/core/bdb_out_reg.sv */
// result register between the update logic and the output channel
// depends on bdb_pkg
`timescale 1ns / 1ps

module bdb_out_reg import bdb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  bdb_out_t res_i,
  output logic     space_o,
  output logic     valid_o,
  input  logic     ready_i,
  output bdb_out_t res_o
);

  logic     valid_q, valid_d;
  bdb_out_t res_q;

  // a held result leaving this cycle frees the slot for the next item
  assign space_o = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !ready_i |-> !load_i)
    else $error("result overwritten before it was taken");

endmodule
